@@ design/ludl_pkg.sv @@
// Package for the Doolittle LU block: sizes, field widths, sequencer states.
// No dependencies.
package ludl_pkg;
    localparam int MAX_DIM_DEF = 8;
    localparam int ELEM_W      = 32;
    localparam int SIZE_W      = 4;
    localparam int IDX_W       = 3;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
    localparam logic ADDR_MATRIX_SIZE = 1'b0;

    typedef enum logic [3:0] {
        ST_LOAD, ST_INIT, ST_RD, ST_MAC_RD, ST_MAC_MUL, ST_MAC_ACC, ST_FIN,
        ST_DIV, ST_WB, ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD
    } state_t;
endpackage

@@ design/ludl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ludl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/ludl_div.sv @@
// Restoring divider, one quotient bit per cycle: 64-bit magnitude by 32-bit magnitude.
// Uses ludl_pkg.
module ludl_div
    import ludl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [63:0] quo
);
    logic [63:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[31:0], q_reg[63]} - {1'b0, den_reg};
        done      = 1'b0;
        if (start) begin
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[32]) begin
                rem_next = {rem_reg[31:0], q_reg[63]};
                q_next   = {q_reg[62:0], 1'b0};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end
    assign quo = q_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end
endmodule

@@ design/lu_decomposition_doolittle.sv @@
// Top level of the Doolittle LU block: load, in-place factoring, result stream.
// Uses ludl_pkg, ludl_ram, ludl_div.
//
// channel  dir  tdata bits                                       tuser / tlast
// s_axis   in   [31:0] element                                   -
// m_axis   out  [2:0] row [5:3] col [37:6] lower [69:38] upper  tuser[0] zero_pivot
//                                                                tuser[1] overflow, tlast
// apb      in   reg 0 at 0x0: matrix_size
//
// Loading accepts one element per cycle. Factoring runs on one shared multiply-subtract
// and one bit-serial divider. Each result is read from memory, registered and held on
// m_axis until accepted.
// Reset is synchronous; the matrix memory needs no clearing. A config write during loading restarts it.
module lu_decomposition_doolittle
    import ludl_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [2:0] row, [5:3] col, [37:6] lower, [69:38] upper
    output logic [1:0]  m_axis_tuser,   // [0] zero_pivot, [1] overflow
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(MAX_DIM);
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

    state_t state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [DW:0]  n;
    logic [DW-1:0] r_reg, r_next, c_reg, c_next, i_reg, i_next, k_reg, k_next,
                   t_reg, t_next;
    logic         low_reg, low_next;       // computing L (column i) vs U (row i)
    logic         opb_reg, opb_next;       // second operand read in flight
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] opa_reg, opa_next, piv_reg, piv_next;
    logic signed [63:0] prod_reg;
    logic         perr_reg, perr_next, sat_reg, sat_next;
    logic [71:0]  otd_reg, otd_next;
    logic         olast_reg, olast_next;
    logic         wr_cfg;

    logic         we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]  wdata, rdata;

    logic         div_start, div_done;
    logic [63:0]  div_num, div_quo;
    logic [31:0]  div_den;

    ludl_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    ludl_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo)
    );

    function automatic logic [AW-1:0] addr_of(input logic [DW-1:0] a, input logic [DW-1:0] b);
        addr_of = AW'(a) * AW'(MAX_DIM) + AW'(b);
    endfunction

    assign pready = 1'b1;
    assign prdata = {{(32-SIZE_W){1'b0}}, size_reg};
    assign wr_cfg = psel && penable && pwrite && (paddr == ADDR_MATRIX_SIZE);

    always_comb begin
        if (size_reg == '0) begin
            n = (DW+1)'(1);
        end else if (32'(size_reg) > MAX_DIM) begin
            n = (DW+1)'(MAX_DIM);
        end else begin
            n = (DW+1)'(size_reg);
        end
    end

    logic [DW-1:0] last_idx;
    assign last_idx = DW'(n - (DW+1)'(1));
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT_HOLD);
    assign m_axis_tdata  = otd_reg;
    assign m_axis_tuser  = {sat_reg, perr_reg};
    assign m_axis_tlast  = olast_reg;

    logic signed [63:0] diff, qs;
    logic signed [31:0] sat_u;
    logic               ovf_sub, neg;
    logic [63:0]        un;
    logic [31:0]        ud;
    logic signed [63:0] acc_u;

    always_comb begin
        diff    = acc_reg - prod_reg;
        ovf_sub = (acc_reg[63] != prod_reg[63]) && (diff[63] != acc_reg[63]);
        acc_u   = acc_reg >>> 16;
        if (acc_reg[63] && (acc_reg[15:0] != '0)) begin
            acc_u = acc_u + 64'sd1;
        end
        neg = acc_reg[63] ^ piv_reg[31];
        un  = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        ud  = piv_reg[31] ? 32'(-piv_reg) : 32'(piv_reg);
        qs  = neg ? -$signed(div_quo) : $signed(div_quo);
        sat_u = acc_u[31:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_axis_tvalid && (c_reg == last_idx) && (r_reg == last_idx)) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: state_next = ST_RD;
            ST_RD: state_next = ST_MAC_RD;
            ST_MAC_RD: begin
                if (opb_reg) begin
                    state_next = ST_MAC_ACC;
                end else if (t_reg == i_reg) begin
                    state_next = low_reg ? ST_DIV : ST_FIN;
                end else begin
                    state_next = ST_MAC_MUL;
                end
            end
            ST_MAC_MUL: state_next = ST_MAC_RD;
            ST_MAC_ACC: begin
                if (t_reg == i_reg) begin
                    state_next = low_reg ? ST_DIV : ST_FIN;
                end else begin
                    state_next = ST_MAC_MUL;
                end
            end
            ST_FIN: state_next = ST_WB;
            ST_DIV: begin
                if ((piv_reg == '0) || (opb_reg && div_done)) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if ((k_reg == last_idx) && (i_reg == last_idx)) begin
                    state_next = ST_OUT_RD;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: state_next = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (m_axis_tready) begin
                    state_next = olast_reg ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath, memory access and indices
    always_comb begin
        r_next = r_reg; c_next = c_reg; i_next = i_reg; k_next = k_reg; t_next = t_reg;
        low_next = low_reg; opb_next = opb_reg;
        acc_next = acc_reg; opa_next = opa_reg; piv_next = piv_reg;
        perr_next = perr_reg; sat_next = sat_reg;
        otd_next = otd_reg; olast_next = olast_reg;
        we = 1'b0; waddr = addr_of(r_reg, c_reg); wdata = s_axis_tdata;
        raddr = addr_of(r_reg, c_reg);
        div_start = 1'b0; div_num = un; div_den = ud;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_axis_tvalid) begin
                    we = 1'b1;
                    if (c_reg == last_idx) begin
                        c_next = '0;
                        if (r_reg == last_idx) begin
                            r_next = '0;
                        end else begin
                            r_next = r_reg + 1'b1;
                        end
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            ST_INIT: begin
                perr_next = 1'b0; sat_next = 1'b0;
                i_next = '0; k_next = '0; low_next = 1'b0;
            end
            ST_RD: begin
                // entry (i,k) for U, (k,i) for L
                raddr = low_reg ? addr_of(k_reg, i_reg) : addr_of(i_reg, k_reg);
                t_next = '0;
                opb_next = 1'b0;
            end
            ST_MAC_RD: begin
                if (!opb_reg) begin
                    acc_next = {{16{rdata[31]}}, rdata, 16'h0};
                    if (t_reg != i_reg) begin
                        raddr = low_reg ? addr_of(k_reg, t_reg) : addr_of(i_reg, t_reg);
                    end
                end
            end
            ST_MAC_MUL: begin
                opa_next = rdata;
                raddr = low_reg ? addr_of(t_reg, i_reg) : addr_of(t_reg, k_reg);
                t_next = t_reg + 1'b1;
                opb_next = 1'b1;
            end
            ST_MAC_ACC: begin
                // prod_reg holds L*U
                if (ovf_sub) begin
                    sat_next = 1'b1;
                    acc_next = acc_reg[63] ? S64_MIN : S64_MAX;
                end else begin
                    acc_next = diff;
                end
                opb_next = 1'b0;
                if (t_reg != i_reg) begin
                    raddr = low_reg ? addr_of(k_reg, t_reg) : addr_of(i_reg, t_reg);
                end
            end
            ST_FIN: begin
                if (acc_u > 64'sh7FFF_FFFF) begin
                    sat_next = 1'b1; wdata = 32'h7FFF_FFFF;
                end else if (acc_u < -64'sh8000_0000) begin
                    sat_next = 1'b1; wdata = 32'h8000_0000;
                end else begin
                    wdata = sat_u;
                end
                we = 1'b1; waddr = addr_of(i_reg, k_reg);
                if (k_reg == i_reg) begin
                    piv_next = $signed(wdata);
                end
            end
            ST_DIV: begin
                if (piv_reg == '0) begin
                    perr_next = 1'b1;
                    we = 1'b1; waddr = addr_of(k_reg, i_reg); wdata = '0;
                end else if (!opb_reg) begin
                    div_start = 1'b1;
                    opb_next = 1'b1;
                end else if (div_done) begin
                    opb_next = 1'b0;
                    we = 1'b1; waddr = addr_of(k_reg, i_reg);
                    if (!neg && div_quo > 64'h7FFF_FFFF) begin
                        sat_next = 1'b1; wdata = 32'h7FFF_FFFF;
                    end else if (neg && div_quo > 64'h8000_0000) begin
                        sat_next = 1'b1; wdata = 32'h8000_0000;
                    end else begin
                        wdata = qs[31:0];
                    end
                end
            end
            ST_WB: begin
                opb_next = 1'b0;
                if (k_reg == last_idx) begin
                    if (!low_reg && i_reg != last_idx) begin
                        low_next = 1'b1; k_next = i_reg + 1'b1;
                    end else if (i_reg == last_idx) begin
                        r_next = '0; c_next = '0;
                    end else begin
                        low_next = 1'b0; i_next = i_reg + 1'b1; k_next = i_reg + 1'b1;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_OUT_RD: begin
                raddr = addr_of(r_reg, c_reg);
            end
            ST_OUT_WAIT: begin
                otd_next = {2'b00,
                            (c_reg >= r_reg) ? rdata : 32'h0,
                            (r_reg == c_reg) ? 32'h0001_0000 :
                            (r_reg > c_reg) ? rdata : 32'h0,
                            3'(c_reg), 3'(r_reg)};
                olast_next = (r_reg == last_idx) && (c_reg == last_idx);
            end
            ST_OUT_HOLD: begin
                if (m_axis_tready) begin
                    if (olast_reg) begin
                        r_next = '0; c_next = '0;
                    end else begin
                        if (c_reg == last_idx) begin
                            c_next = '0; r_next = r_reg + 1'b1;
                        end else begin
                            c_next = c_reg + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (wr_cfg) begin
            r_next = '0; c_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            size_reg  <= SIZE_RESET;
            r_reg <= '0; c_reg <= '0;
            perr_reg <= 1'b0; sat_reg <= 1'b0;
            opb_reg <= 1'b0; low_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_cfg) begin
                size_reg <= pwdata[SIZE_W-1:0];
            end
            r_reg <= r_next; c_reg <= c_next;
            perr_reg <= perr_next; sat_reg <= sat_next;
            opb_reg <= opb_next; low_reg <= low_next;
        end
        i_reg <= i_next; k_reg <= k_next; t_reg <= t_next;
        acc_reg <= acc_next; opa_reg <= opa_next; piv_reg <= piv_next;
        otd_reg <= otd_next; olast_reg <= olast_next;
        prod_reg <= opa_reg * $signed(rdata);
    end
endmodule

@@ bench/lu_decomposition_doolittle_chk.sv @@
// Checker for the Doolittle LU block: watches the element and result streams,
// recomputes the factors in Q16.16 and compares each result beat. Uses ludl_pkg.
`timescale 1ns / 100ps
module lu_decomposition_doolittle_chk
    import ludl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] lower;
        logic [31:0] upper;
        logic        zero_pivot;
        logic        overflow;
        logic        last;
    } lu_beat_t;

    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

    lu_beat_t          lu_expected[$];
    logic signed [31:0] elem_mem[MAX_DIM_DEF][MAX_DIM_DEF];
    logic [SIZE_W-1:0] size_reg;
    int                load_cnt;
    bit                sat_flag;

    assign pending = lu_expected.size();

    function automatic int dim_used();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(size_reg);
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        if (b > 0 && a < S64_MIN + b) begin
            sat_flag = 1;
            return S64_MIN;
        end
        if (b < 0 && a > S64_MAX + b) begin
            sat_flag = 1;
            return S64_MAX;
        end
        return a - b;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sh7FFF_FFFF) begin
            sat_flag = 1;
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            sat_flag = 1;
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    function automatic longint quot_sat(longint num, longint den);
        logic [63:0] un, ud, q;
        bit neg;
        un  = num < 0 ? 64'd0 - 64'(num) : 64'(num);
        ud  = den < 0 ? 64'd0 - 64'(den) : 64'(den);
        q   = un / ud;
        neg = (num < 0) != (den < 0);
        if (neg) begin
            if (q > 64'h8000_0000) begin
                sat_flag = 1;
                return -64'sh8000_0000;
            end
            return -longint'(q);
        end
        if (q > 64'h7FFF_FFFF) begin
            sat_flag = 1;
            return 64'sh7FFF_FFFF;
        end
        return longint'(q);
    endfunction

    task automatic factor_matrix();
        longint lo[MAX_DIM_DEF][MAX_DIM_DEF];
        longint up[MAX_DIM_DEF][MAX_DIM_DEF];
        longint acc;
        bit piv;
        int n;
        lu_beat_t b;
        n = dim_used();
        piv = 0;
        sat_flag = 0;
        for (int i = 0; i < MAX_DIM_DEF; i++)
            for (int k = 0; k < MAX_DIM_DEF; k++) begin
                lo[i][k] = (i == k) ? 65536 : 0;
                up[i][k] = 0;
            end
        for (int i = 0; i < n; i++) begin
            for (int k = i; k < n; k++) begin
                acc = longint'(elem_mem[i][k]) * 65536;
                for (int t = 0; t < i; t++) acc = sub_sat(acc, lo[i][t] * up[t][k]);
                up[i][k] = clip32(acc / 65536);
            end
            for (int k = i + 1; k < n; k++) begin
                acc = longint'(elem_mem[k][i]) * 65536;
                for (int t = 0; t < i; t++) acc = sub_sat(acc, lo[k][t] * up[t][i]);
                if (up[i][i] == 0) begin
                    piv = 1;
                    lo[k][i] = 0;
                end else begin
                    lo[k][i] = quot_sat(acc, up[i][i]);
                end
            end
        end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                b.row = 3'(r);
                b.col = 3'(c);
                b.lower = lo[r][c][31:0];
                b.upper = up[r][c][31:0];
                b.zero_pivot = piv;
                b.overflow = sat_flag;
                b.last = (r == n - 1) && (c == n - 1);
                lu_expected.push_back(b);
            end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        lu_beat_t w;
        int n;
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
            load_cnt = 0;
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_MATRIX_SIZE) begin
                size_reg <= pwdata[SIZE_W-1:0];
                load_cnt = 0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n = dim_used();
                if (load_cnt >= n * n) load_cnt = 0;
                elem_mem[load_cnt / n][load_cnt % n] = s_axis_tdata;
                load_cnt++;
                if (load_cnt == n * n) begin
                    load_cnt = 0;
                    factor_matrix();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (lu_expected.size() == 0) begin
                    $display("%0t unexpected result beat", $time);
                    fail_count++;
                end else begin
                    w = lu_expected.pop_front();
                    if (m_axis_tdata[2:0] != w.row) report("row", m_axis_tdata[2:0], w.row);
                    if (m_axis_tdata[5:3] != w.col) report("col", m_axis_tdata[5:3], w.col);
                    if (m_axis_tdata[37:6] != w.lower)
                        report("lower", m_axis_tdata[37:6], w.lower);
                    if (m_axis_tdata[69:38] != w.upper)
                        report("upper", m_axis_tdata[69:38], w.upper);
                    if (m_axis_tuser[0] != w.zero_pivot)
                        report("zero_pivot", m_axis_tuser[0], w.zero_pivot);
                    if (m_axis_tuser[1] != w.overflow)
                        report("overflow", m_axis_tuser[1], w.overflow);
                    if (m_axis_tlast != w.last) report("last", m_axis_tlast, w.last);
                end
            end
        end
    end
endmodule

@@ bench/tb_lu_decomposition_doolittle.sv @@
// Top of the Doolittle LU testbench: clock, reset, APB size writes, element stimulus
// and result back-pressure. Uses ludl_pkg, the block and lu_decomposition_doolittle_chk.
`timescale 1ns / 100ps
module tb_lu_decomposition_doolittle;
    import ludl_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] element
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;    // [2:0] row, [5:3] col, [37:6] lower, [69:38] upper
    logic [1:0]  m_axis_tuser;    // [0] zero_pivot, [1] overflow
    logic        m_axis_tlast;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          draining;

    lu_decomposition_doolittle u_dut (.*);
    lu_decomposition_doolittle_chk u_chk (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] rand_elem(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
            2: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    task automatic send_elem(logic [31:0] v);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= v;
        @(posedge aclk iff s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_size(logic [31:0] v);
        s_axis_tvalid <= 0;
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_MATRIX_SIZE; pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_matrix(int n, int kind);
        for (int i = 0; i < n * n; i++) send_elem(rand_elem(kind));
    endtask

    // result-side back-pressure
    initial begin
        int g;
        m_axis_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (draining || $urandom_range(0, 3) != 0) m_axis_tready <= 1;
            else begin
                g = gap_len();
                if (g > 0) begin
                    m_axis_tready <= 0;
                    repeat (g) @(negedge aclk);
                    m_axis_tready <= 1;
                end
            end
        end
    end

    initial begin
        int n, sent, reps;
        s_axis_tvalid = 0; s_axis_tdata = 0; draining = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        aresetn = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);
        // reset size 8: identity-like and extremes
        for (int i = 0; i < 64; i++)
            send_elem(i % 9 == 0 ? 32'h0001_0000 : (i < 2 ? 32'h7FFF_FFFF : 32'h8000_0000));
        wait_idle();
        write_size(1);
        send_elem(32'h0000_0000);
        send_elem(32'h8000_0000);
        send_elem(32'h7FFF_FFFF);
        send_elem(32'hFFFF_FFFF);
        wait_idle();
        write_size(2);      // zero pivot in first column
        send_elem(0); send_elem(32'h0002_0000); send_elem(32'h0003_0000); send_elem(32'h1);
        wait_idle();
        write_size(0);      // treated as 1
        send_elem(32'h0005_0000);
        wait_idle();
        write_size(15);     // treated as max
        send_matrix(8, 1);
        wait_idle();
        write_size(3);
        send_elem(32'h0001_0000);  // partial load dropped by the next write
        write_size(3);
        send_matrix(3, 3);
        wait_idle();
        sent = 0;
        while (sent < 260) begin
            n = $urandom_range(0, 9) == 0 ? 8 : $urandom_range(1, 4);
            write_size({$urandom_range(0, 1) ? 28'hFFF_FFFF : 28'h0, 4'(n)});
            reps = $urandom_range(1, 3);
            for (int m = 0; m < reps && sent < 260; m++) begin
                send_matrix(n, $urandom_range(0, 3));
                sent += n * n;
            end
            wait_idle();
        end
        draining = 1;
        wait_idle();
        if (fail_count == 0) $display("lu_decomposition_doolittle verification clean");
        else $display("lu_decomposition_doolittle verification failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("lu_decomposition_doolittle verification failed");
        $finish;
    end
endmodule
